// ===== rtl/stepseq_pkg.sv =====
// ----------------------------------------------------------------------------
// Step sequencer package
// Shared constants: request codes, configuration indexes, frame codes, sizes.
// ----------------------------------------------------------------------------
package stepseq_pkg;

	localparam int STEPS_DEF    = 1024;
	localparam int CHANNELS_DEF = 16;

	localparam int REQ_W   = 2;
	localparam int CHAN_W  = 4;
	localparam int STEP_W  = 10;
	localparam int CODE_W  = 16;
	localparam int DELTA_W = 13;
	localparam int CFG_W   = 1;

	typedef logic [REQ_W-1:0] req_t;

	localparam req_t REQ_TICK = 2'd0;
	localparam req_t REQ_SET  = 2'd1;
	localparam req_t REQ_ADJ  = 2'd2;
	localparam req_t REQ_POS  = 2'd3;

	localparam logic [CFG_W-1:0] CFG_RUN = 1'd0;
	localparam logic [CFG_W-1:0] CFG_REC = 1'd1;

	localparam logic [CODE_W-1:0] CODE_FULL = 16'hFFFF;
	localparam logic [CODE_W-1:0] CODE_HALF = 16'h7FFF;
	localparam logic [CODE_W-1:0] CODE_ZERO = 16'h0000;

endpackage

// ===== rtl/stepseq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module stepseq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold the last read word when no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/step_sequencer_dac_frames_core.sv =====
// ----------------------------------------------------------------------------
// Step sequencer DAC frame core
// Pattern store in one RAM, ticks turn the current step into DAC frames.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | beat carries
//  in      | sink      | in_valid/in_ready   | req_type chan step_index entry_value delta
//  out     | source    | out_valid/out_ready | dac_channel dac_word last_frame
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_index cfg_data
//
// After reset the pattern RAM is swept to zero, one entry a cycle; in_ready is
// low during the sweep, cfg beats are taken at any time.
// Set position and set entry are done as the request is taken; adjust entry
// reads the entry, then writes the saturated sum back.
// A running tick sends the two channel 0 frames, then does one RAM read and one
// evaluation per channel from channel 1 up, plus a 0x7FFF frame for each 0xFFFF
// entry; out_ready low stalls it.
// ----------------------------------------------------------------------------
module step_sequencer_dac_frames_core #(
	parameter int STEPS    = stepseq_pkg::STEPS_DEF,
	parameter int CHANNELS = stepseq_pkg::CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [stepseq_pkg::REQ_W-1:0]     req_type,
	input  logic [stepseq_pkg::CHAN_W-1:0]    chan,
	input  logic [stepseq_pkg::STEP_W-1:0]    step_index,
	input  logic [stepseq_pkg::CODE_W-1:0]    entry_value,
	input  logic signed [stepseq_pkg::DELTA_W-1:0] delta,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [stepseq_pkg::CHAN_W-1:0]    dac_channel,
	output logic [stepseq_pkg::CODE_W-1:0]    dac_word,
	output logic                              last_frame,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [stepseq_pkg::CFG_W-1:0]     cfg_index,
	input  logic                              cfg_data
);

	import stepseq_pkg::*;

	localparam int PW    = $clog2(STEPS);
	localparam int CW    = $clog2(CHANNELS);
	localparam int AW    = CW + PW;
	localparam int DEPTH = CHANNELS << PW;
	localparam int SUM_W = CODE_W + 2;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_ADJ  = 4'd2;
	localparam logic [3:0] S_T0A  = 4'd3;
	localparam logic [3:0] S_T0B  = 4'd4;
	localparam logic [3:0] S_RD   = 4'd5;
	localparam logic [3:0] S_EV   = 4'd6;
	localparam logic [3:0] S_EV2  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0]        state_q;
	logic [AW-1:0]     clr_addr_q;
	logic [PW-1:0]     pos_q;
	logic [CW-1:0]     ch_q;
	logic              run_q;
	logic              rec_q;
	logic [AW-1:0]     ed_addr_q;
	logic signed [DELTA_W-1:0] delta_q;

	logic              pend_v_q;
	logic [CW-1:0]     pend_ch_q;
	logic [CODE_W-1:0] pend_code_q;

	logic              out_v_q;
	logic [CHAN_W-1:0] out_ch_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_last_q;

	logic              in_acc;
	logic              edit_ok;
	logic [AW-1:0]     in_addr;
	logic              out_free;
	logic              can_push;
	logic              push;
	logic              out_load;
	logic [CW-1:0]     gen_ch;
	logic [CODE_W-1:0] gen_code;
	logic              last_ch;
	logic [PW-1:0]     pos_next;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CODE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CODE_W-1:0] mem_rdata;

	logic signed [SUM_W-1:0] sum;
	logic [CODE_W-1:0]       sat;

	stepseq_ram #(
		.WIDTH (CODE_W),
		.DEPTH (DEPTH)
	) u_pattern_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign edit_ok   = rec_q && (32'(chan) < CHANNELS) && (32'(step_index) < STEPS);
	assign in_addr   = {CW'(chan), PW'(step_index)};

	assign out_free  = !out_v_q || out_ready;
	assign can_push  = !pend_v_q || out_free;
	assign out_load  = (push && pend_v_q) || ((state_q == S_FIN) && out_free);
	assign last_ch   = (ch_q == CW'(CHANNELS - 1));
	assign pos_next  = (pos_q == PW'(STEPS - 1)) ? '0 : pos_q + 1'b1;

	// saturating adjust of the stored entry
	assign sum = $signed({2'b00, mem_rdata}) + SUM_W'(delta_q);
	always_comb begin
		if (sum < 0) begin
			sat = CODE_ZERO;
		end else if (sum > $signed(SUM_W'(CODE_FULL))) begin
			sat = CODE_FULL;
		end else begin
			sat = sum[CODE_W-1:0];
		end
	end

	// frame offered to the pending slot in each tick state
	always_comb begin
		gen_ch   = ch_q;
		gen_code = CODE_HALF;
		push     = 1'b0;
		case (state_q)
			S_T0A: begin
				gen_ch   = '0;
				gen_code = CODE_FULL;
				push     = can_push;
			end
			S_T0B: begin
				gen_ch   = '0;
				gen_code = CODE_HALF;
				push     = can_push;
			end
			S_EV: begin
				gen_code = mem_rdata;
				push     = can_push && (mem_rdata != CODE_ZERO);
			end
			S_EV2: begin
				gen_code = CODE_HALF;
				push     = can_push;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = in_addr;
		mem_wdata = entry_value;
		mem_re    = 1'b0;
		mem_raddr = in_addr;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = CODE_ZERO;
			end
			S_IDLE: begin
				mem_we = in_acc && edit_ok && (req_type == REQ_SET);
				mem_re = in_acc && edit_ok && (req_type == REQ_ADJ);
			end
			S_ADJ: begin
				mem_we    = 1'b1;
				mem_waddr = ed_addr_q;
				mem_wdata = sat;
			end
			S_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {ch_q, pos_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_addr_q <= '0;
			pos_q      <= '0;
			ch_q       <= '0;
			run_q      <= 1'b0;
			rec_q      <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RUN: run_q <= cfg_data;
					CFG_REC: rec_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end

			// hand the pending frame on as the next one takes its place
			if (push) begin
				if (pend_v_q) begin
					out_ch_q   <= CHAN_W'(pend_ch_q);
					out_code_q <= pend_code_q;
					out_last_q <= 1'b0;
				end
				pend_v_q    <= 1'b1;
				pend_ch_q   <= gen_ch;
				pend_code_q <= gen_code;
			end

			case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						ed_addr_q <= in_addr;
						delta_q   <= delta;
						case (req_type)
							REQ_TICK: begin
								if (run_q) begin
									state_q <= S_T0A;
								end
							end
							REQ_POS: begin
								pos_q <= (32'(step_index) < STEPS) ? PW'(step_index) : '0;
							end
							REQ_ADJ: begin
								if (edit_ok) begin
									state_q <= S_ADJ;
								end
							end
							default: ;
						endcase
					end
				end
				S_ADJ: begin
					state_q <= S_IDLE;
				end
				S_T0A: begin
					if (push) begin
						state_q <= S_T0B;
					end
				end
				S_T0B: begin
					if (push) begin
						ch_q    <= CW'(1);
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (mem_rdata == CODE_ZERO || push) begin
						if (mem_rdata == CODE_FULL) begin
							state_q <= S_EV2;
						end else if (last_ch) begin
							state_q <= S_FIN;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_EV2: begin
					if (push) begin
						if (last_ch) begin
							state_q <= S_FIN;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_FIN: begin
					// flush the final frame of the tick, then advance the position
					if (out_free) begin
						out_ch_q   <= CHAN_W'(pend_ch_q);
						out_code_q <= pend_code_q;
						out_last_q <= 1'b1;
						pend_v_q   <= 1'b0;
						pos_q      <= pos_next;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_v_q;
	assign dac_channel = out_ch_q;
	assign dac_word    = out_code_q;
	assign last_frame  = out_last_q;

endmodule

// ===== bench/step_sequencer_dac_frames_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step sequencer DAC frame core testbench
// Drives requests and register writes over valid/ready, mirrors the pattern
// store and play position, and checks every DAC frame in order against the
// frames that the mirror predicts. Directed cases come first, random phases
// under several run/record settings follow.
// ----------------------------------------------------------------------------
module step_sequencer_dac_frames_core_tb;
	import stepseq_pkg::*;

	localparam int STEPS      = STEPS_DEF;
	localparam int CHANNELS   = CHANNELS_DEF;
	localparam int SETTLE     = 100;
	localparam int IDLE_LIMIT = 60000;

	typedef struct packed {
		logic [CHAN_W-1:0] ch;
		logic [CODE_W-1:0] code;
		logic              last;
	} frame_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic [REQ_W-1:0]          req_type    = REQ_TICK;
	logic [CHAN_W-1:0]         chan        = '0;
	logic [STEP_W-1:0]         step_index  = '0;
	logic [CODE_W-1:0]         entry_value = '0;
	logic signed [DELTA_W-1:0] delta       = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic [CHAN_W-1:0]         dac_channel;
	logic [CODE_W-1:0]         dac_word;
	logic                      last_frame;
	logic                      cfg_valid   = 1'b0;
	logic                      cfg_ready;
	logic [CFG_W-1:0]          cfg_index   = CFG_RUN;
	logic                      cfg_data    = 1'b0;

	// mirror of the block
	logic [CODE_W-1:0] pattern_mirror [CHANNELS][STEPS];
	logic [STEP_W-1:0] pos_mirror;
	logic              run_on;
	logic              rec_on;

	frame_t frames_due [$];
	int     n_errors   = 0;
	int     idle_count = 0;
	bit     steady     = 1'b0;

	step_sequencer_dac_frames_core #(
		.STEPS    (STEPS),
		.CHANNELS (CHANNELS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.chan        (chan),
		.step_index  (step_index),
		.entry_value (entry_value),
		.delta       (delta),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dac_channel (dac_channel),
		.dac_word    (dac_word),
		.last_frame  (last_frame),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// frames expected from one request, appended in playing order
	task automatic predict_frames(req_t r, logic [CHAN_W-1:0] c, logic [STEP_W-1:0] s,
			logic [CODE_W-1:0] v, logic signed [DELTA_W-1:0] d);
		frame_t burst [$];
		logic [CODE_W-1:0] e;
		int sum;
		if (r == REQ_TICK) begin
			if (!run_on)
				return;
			burst.push_back('{ch: '0, code: CODE_FULL, last: 1'b0});
			burst.push_back('{ch: '0, code: CODE_HALF, last: 1'b0});
			for (int k = 1; k < CHANNELS; k++) begin
				e = pattern_mirror[k][pos_mirror];
				if (e == CODE_FULL) begin
					burst.push_back('{ch: CHAN_W'(k), code: CODE_FULL, last: 1'b0});
					burst.push_back('{ch: CHAN_W'(k), code: CODE_HALF, last: 1'b0});
				end else if (e != CODE_ZERO) begin
					burst.push_back('{ch: CHAN_W'(k), code: e, last: 1'b0});
				end
			end
			burst[burst.size()-1].last = 1'b1;
			foreach (burst[i])
				frames_due.push_back(burst[i]);
			pos_mirror = (int'(pos_mirror) >= STEPS - 1) ? '0 : pos_mirror + 1'b1;
		end else if (r == REQ_POS) begin
			pos_mirror = (int'(s) < STEPS) ? s : '0;
		end else if (rec_on && int'(c) < CHANNELS && int'(s) < STEPS) begin
			if (r == REQ_SET) begin
				pattern_mirror[c][s] = v;
			end else begin
				sum = int'(pattern_mirror[c][s]) + int'(d);
				if (sum < 0)
					sum = 0;
				if (sum > 16'hFFFF)
					sum = 16'hFFFF;
				pattern_mirror[c][s] = CODE_W'(sum);
			end
		end
	endtask

	function automatic int pick_gap();
		if (steady || $urandom_range(99) >= 30)
			return 0;
		if ($urandom_range(4) == 0)
			return $urandom_range(40, 5);
		return $urandom_range(4, 1);
	endfunction

	task automatic send_request(req_t r, logic [CHAN_W-1:0] c, logic [STEP_W-1:0] s,
			logic [CODE_W-1:0] v, logic signed [DELTA_W-1:0] d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= r;
		chan        <= c;
		step_index  <= s;
		entry_value <= v;
		delta       <= d;
		do @(posedge clk); while (!in_ready);
		predict_frames(r, c, s, v, d);
	endtask

	// hold valid high across back-to-back writes; set_mode drops it
	task automatic write_reg(logic [CFG_W-1:0] idx, logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_RUN)
			run_on = val;
		else
			rec_on = val;
	endtask

	task automatic set_mode(logic run, logic rec);
		write_reg(CFG_RUN, run);
		write_reg(CFG_REC, rec);
		cfg_valid <= 1'b0;
	endtask

	// wait for outstanding frames, then let edits with no frames finish
	task automatic drain();
		in_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic test_stopped_and_locked();
		send_request(REQ_TICK, 4'd0, 10'd0, 16'h0000, 13'sd0);
		send_request(REQ_SET, 4'd5, 10'd3, 16'h1234, 13'sd0);
		send_request(REQ_ADJ, 4'd5, 10'd3, 16'h0000, 13'sd100);
		send_request(REQ_POS, 4'd0, 10'd3, 16'h0000, 13'sd0);
		drain();
		set_mode(1'b1, 1'b0);
		send_request(REQ_TICK, 4'd0, 10'd0, 16'h0000, 13'sd0);
		drain();
	endtask

	task automatic test_entry_edits();
		set_mode(1'b0, 1'b1);
		send_request(REQ_SET, 4'd15, 10'd1023, 16'hFFFF, 13'sd0);
		send_request(REQ_SET, 4'd1, 10'd1023, 16'h0001, 13'sd0);
		send_request(REQ_ADJ, 4'd1, 10'd1023, 16'h0000, 13'sd4095);
		send_request(REQ_SET, 4'd2, 10'd1023, 16'hFFFE, 13'sd0);
		// clamp at the top
		send_request(REQ_ADJ, 4'd2, 10'd1023, 16'h0000, 13'sd4095);
		send_request(REQ_SET, 4'd3, 10'd0, 16'h00FF, 13'sd0);
		// clamp at zero
		send_request(REQ_ADJ, 4'd3, 10'd0, 16'h0000, -13'sd4095);
		send_request(REQ_SET, 4'd4, 10'd0, 16'h0FFF, 13'sd0);
		send_request(REQ_ADJ, 4'd4, 10'd0, 16'h0000, -13'sd4095);
		send_request(REQ_ADJ, 4'd5, 10'd0, 16'h0000, 13'sd1);
		// channel 0 entry is never played
		send_request(REQ_SET, 4'd0, 10'd0, 16'h7FFF, 13'sd0);
		drain();
	endtask

	task automatic test_play_wrap();
		set_mode(1'b1, 1'b1);
		send_request(REQ_POS, 4'd0, 10'd1023, 16'h0000, 13'sd0);
		send_request(REQ_TICK, 4'd0, 10'd0, 16'h0000, 13'sd0);
		send_request(REQ_TICK, 4'd0, 10'd0, 16'h0000, 13'sd0);
		send_request(REQ_TICK, 4'd0, 10'd0, 16'h0000, 13'sd0);
		drain();
	endtask

	task automatic random_phase(logic run, logic rec, int count);
		logic [STEP_W-1:0] base;
		logic [STEP_W-1:0] s;
		logic [CODE_W-1:0] v;
		logic signed [DELTA_W-1:0] d;
		int pick;
		req_t r;
		set_mode(run, rec);
		// keep most steps in a small window so ticks land on edited entries
		case ($urandom_range(2))
			0: base = '0;
			1: base = 10'd1020;
			default: base = STEP_W'($urandom);
		endcase
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 35)
				r = REQ_TICK;
			else if (pick < 65)
				r = REQ_SET;
			else if (pick < 85)
				r = REQ_ADJ;
			else
				r = REQ_POS;
			if ($urandom_range(99) < 85)
				s = STEP_W'(base + $urandom_range(7));
			else
				s = STEP_W'($urandom);
			case ($urandom_range(5))
				0: v = CODE_ZERO;
				1: v = CODE_FULL;
				2: v = 16'hFFFE;
				3: v = 16'h0001;
				default: v = CODE_W'($urandom);
			endcase
			case ($urandom_range(4))
				0: d = 13'sd4095;
				1: d = -13'sd4095;
				default: d = DELTA_W'(int'($urandom_range(8190)) - 4095);
			endcase
			send_request(r, CHAN_W'($urandom), s, v, d);
		end
		drain();
	endtask

	task automatic test_random_phases();
		steady = 1'b1;
		random_phase(1'b1, 1'b1, 25);
		steady = 1'b0;
		random_phase(1'b1, 1'b0, 20);
		random_phase(1'b0, 1'b1, 20);
		random_phase(1'b1, 1'b1, 35);
	endtask

	always @(posedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
	end

	// compare each DAC frame with the oldest one predicted
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frames_due.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected frame ch=%0d code=%h last=%b",
					$time, dac_channel, dac_word, last_frame);
			end else begin
				want = frames_due.pop_front();
				if (dac_channel !== want.ch) begin
					n_errors++;
					$display("%0t: dac_channel expected %0d got %0d",
						$time, want.ch, dac_channel);
				end
				if (dac_word !== want.code) begin
					n_errors++;
					$display("%0t: dac_word expected %h got %h", $time, want.code, dac_word);
				end
				if (last_frame !== want.last) begin
					n_errors++;
					$display("%0t: last_frame expected %b got %b",
						$time, want.last, last_frame);
				end
			end
		end
	end

	// counts cycles with no beat on any channel; covers the clearing sweep
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("step_sequencer_dac_frames_core regression: fail");
			$finish;
		end
	end

	initial begin
		foreach (pattern_mirror[c, s])
			pattern_mirror[c][s] = CODE_ZERO;
		pos_mirror = '0;
		run_on     = 1'b0;
		rec_on     = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_stopped_and_locked();
		test_entry_edits();
		test_play_wrap();
		test_random_phases();
		drain();
		if (n_errors == 0)
			$display("step_sequencer_dac_frames_core regression: pass");
		else
			$display("step_sequencer_dac_frames_core regression: fail");
		$finish;
	end

endmodule
